[rtl/qlsf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// qlsf_pkg
// Shared types, constants and the solve program of the quadratic fit block.
// ============================================================================
package qlsf_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int MAX_POINTS  = 256;
  localparam int FRAC_BITS   = 16;

  localparam int CNT_W    = $clog2(MAX_POINTS + 1);
  localparam int PT_W     = $clog2(MAX_POINTS);
  localparam int CFG_W    = 5;
  localparam logic [CFG_W-1:0] MIN_POINTS_RST = CFG_W'(4);

  localparam int SUM_X4_W  = 4 * SAMPLE_BITS - 3 + PT_W;
  localparam int SUM_X3_W  = 3 * SAMPLE_BITS - 1 + PT_W;
  localparam int SUM_X2_W  = 2 * SAMPLE_BITS - 1 + PT_W;
  localparam int SUM_X_W   = SAMPLE_BITS + 1 + PT_W;
  localparam int SUM_X2Y_W = 3 * SAMPLE_BITS - 1 + PT_W;
  localparam int SUM_XY_W  = 2 * SAMPLE_BITS + PT_W;
  localparam int SUM_Y_W   = SAMPLE_BITS + 1 + PT_W;

  // Datapath width of the solver and the coefficient width.
  localparam int DW     = 128;
  localparam int MC_W   = $clog2(DW);
  localparam int COEF_W = 32;

  localparam int PROG_LEN = 24;
  localparam int PC_W     = $clog2(PROG_LEN);

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FEW      = 3'd1,
    ST_SINGULAR = 3'd2,
    ST_SAT      = 3'd3,
    ST_DROPPED  = 3'd4
  } status_t;

  typedef struct packed {
    logic signed [SUM_X4_W-1:0]  x4;
    logic signed [SUM_X3_W-1:0]  x3;
    logic signed [SUM_X2_W-1:0]  x2;
    logic signed [SUM_X_W-1:0]   x1;
    logic signed [SUM_X2Y_W-1:0] x2y;
    logic signed [SUM_XY_W-1:0]  xy;
    logic signed [SUM_Y_W-1:0]   y1;
  } sums_t;

  typedef struct packed {
    logic [COEF_W-1:0] coef_a;
    logic [COEF_W-1:0] coef_b;
    logic [COEF_W-1:0] coef_c;
    status_t           status;
    logic [CNT_W-1:0]  count;
  } result_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_ACC,
    T_START,
    T_SOLVE
  } top_state_t;

  typedef enum logic [3:0] {
    SV_IDLE,
    SV_LOAD,
    SV_MUL,
    SV_MAC,
    SV_ABSD,
    SV_ABSN,
    SV_DIV,
    SV_QUOT,
    SV_DONE
  } sv_state_t;

  typedef enum logic [3:0] {
    SRC_S4, SRC_S3, SRC_S2, SRC_S1, SRC_S0,
    SRC_T2, SRC_T1, SRC_T0,
    SRC_M0, SRC_M1, SRC_M2, SRC_N1, SRC_N2, SRC_P2
  } src_t;

  typedef enum logic [3:0] {
    DST_NONE,
    DST_M0, DST_M1, DST_M2, DST_N1, DST_N2, DST_P2,
    DST_D, DST_DA, DST_DB, DST_DC
  } dst_t;

  typedef enum logic [1:0] {
    MAC_LOAD,
    MAC_ADD,
    MAC_SUB
  } mac_t;

  typedef struct packed {
    src_t a;
    src_t b;
    mac_t mode;
    dst_t dst;
  } instr_t;

  // Solve program: 2x2 minors first, then the system determinant and the
  // three Cramer numerators expanded along the replaced column.
  function automatic instr_t prog_rom(input logic [PC_W-1:0] pc);
    instr_t ins;
    unique case (pc)
      PC_W'(0):  ins = '{SRC_S2, SRC_S0, MAC_LOAD, DST_NONE};
      PC_W'(1):  ins = '{SRC_S1, SRC_S1, MAC_SUB,  DST_M0};
      PC_W'(2):  ins = '{SRC_S3, SRC_S0, MAC_LOAD, DST_NONE};
      PC_W'(3):  ins = '{SRC_S2, SRC_S1, MAC_SUB,  DST_M1};
      PC_W'(4):  ins = '{SRC_S3, SRC_S1, MAC_LOAD, DST_NONE};
      PC_W'(5):  ins = '{SRC_S2, SRC_S2, MAC_SUB,  DST_M2};
      PC_W'(6):  ins = '{SRC_S4, SRC_S0, MAC_LOAD, DST_NONE};
      PC_W'(7):  ins = '{SRC_S2, SRC_S2, MAC_SUB,  DST_N1};
      PC_W'(8):  ins = '{SRC_S4, SRC_S1, MAC_LOAD, DST_NONE};
      PC_W'(9):  ins = '{SRC_S3, SRC_S2, MAC_SUB,  DST_N2};
      PC_W'(10): ins = '{SRC_S4, SRC_S2, MAC_LOAD, DST_NONE};
      PC_W'(11): ins = '{SRC_S3, SRC_S3, MAC_SUB,  DST_P2};
      PC_W'(12): ins = '{SRC_S4, SRC_M0, MAC_LOAD, DST_NONE};
      PC_W'(13): ins = '{SRC_S3, SRC_M1, MAC_SUB,  DST_NONE};
      PC_W'(14): ins = '{SRC_S2, SRC_M2, MAC_ADD,  DST_D};
      PC_W'(15): ins = '{SRC_T2, SRC_M0, MAC_LOAD, DST_NONE};
      PC_W'(16): ins = '{SRC_T1, SRC_M1, MAC_SUB,  DST_NONE};
      PC_W'(17): ins = '{SRC_T0, SRC_M2, MAC_ADD,  DST_DA};
      PC_W'(18): ins = '{SRC_T1, SRC_N1, MAC_LOAD, DST_NONE};
      PC_W'(19): ins = '{SRC_T2, SRC_M1, MAC_SUB,  DST_NONE};
      PC_W'(20): ins = '{SRC_T0, SRC_N2, MAC_SUB,  DST_DB};
      PC_W'(21): ins = '{SRC_T2, SRC_M2, MAC_LOAD, DST_NONE};
      PC_W'(22): ins = '{SRC_T1, SRC_N2, MAC_SUB,  DST_NONE};
      PC_W'(23): ins = '{SRC_T0, SRC_P2, MAC_ADD,  DST_DC};
      default:   ins = '{SRC_S4, SRC_S4, MAC_LOAD, DST_NONE};
    endcase
    return ins;
  endfunction

endpackage
`default_nettype wire

[rtl/qlsf_accum.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// qlsf_accum
// Power-sum accumulator: squares the sample, then adds all products.
// ============================================================================
module qlsf_accum
  import qlsf_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          take,
  input  wire logic signed [SAMPLE_BITS-1:0] x_value,
  input  wire logic signed [SAMPLE_BITS-1:0] y_value,
  input  wire logic                          add_en,
  input  wire logic                          clear,
  output sums_t                              sums,
  output logic [CNT_W-1:0]                   count,
  output logic                               overflow
);

  logic signed [SAMPLE_BITS-1:0]   x_r;
  logic signed [SAMPLE_BITS-1:0]   y_r;
  logic signed [2*SAMPLE_BITS-1:0] x2_r;

  logic signed [3*SAMPLE_BITS-1:0] x3;
  logic signed [4*SAMPLE_BITS-1:0] x4;
  logic signed [2*SAMPLE_BITS-1:0] xy;
  logic signed [3*SAMPLE_BITS-1:0] x2y;

  // Register the sample and its square.
  always_ff @(posedge clk) begin
    if (take) begin
      x_r  <= x_value;
      y_r  <= y_value;
      x2_r <= x_value * x_value;
    end
  end

  assign x3  = x2_r * x_r;
  assign x4  = x2_r * x2_r;
  assign xy  = x_r * y_r;
  assign x2y = x2_r * y_r;

  // Then add into the sums unless the set is already full.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      sums     <= '0;
      count    <= '0;
      overflow <= 1'b0;
    end else if (add_en) begin
      if (count == CNT_W'(MAX_POINTS)) begin
        overflow <= 1'b1;
      end else begin
        sums.x4  <= sums.x4 + SUM_X4_W'(x4);
        sums.x3  <= sums.x3 + SUM_X3_W'(x3);
        sums.x2  <= sums.x2 + SUM_X2_W'(x2_r);
        sums.x1  <= sums.x1 + SUM_X_W'(x_r);
        sums.x2y <= sums.x2y + SUM_X2Y_W'(x2y);
        sums.xy  <= sums.xy + SUM_XY_W'(xy);
        sums.y1  <= sums.y1 + SUM_Y_W'(y_r);
        count    <= count + CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

[rtl/qlsf_solver.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// qlsf_solver
// Cramer solve on one shared wide adder: shift-add multiply, restoring divide.
// ============================================================================
module qlsf_solver
  import qlsf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire sums_t            sums,
  input  wire logic [CNT_W-1:0] count,
  input  wire logic             overflow,
  input  wire logic [CFG_W-1:0] min_points,
  input  wire logic             ack,
  output logic                  done,
  output result_t               res
);

  sv_state_t state, state_next;
  logic [PC_W-1:0] pc;
  logic [MC_W-1:0] cnt;
  logic [1:0]      k;

  sums_t            s_r;
  logic [CNT_W-1:0] used;
  logic             ovf;
  logic             sat;
  logic             neg;

  logic [DW-1:0] m0, m1, m2, n1, n2, p2, d_r, da, db, dc;
  logic [DW-1:0] ma, mb, prod, acc, den, r, n;

  instr_t        instr;
  logic [DW-1:0] opa, opb, num_sel, rsh;
  logic [DW-1:0] add_a, add_b;
  logic          add_sub;
  logic [DW:0]   add_full;
  logic [DW-1:0] add_res;
  logic          carry;
  logic          few;
  logic          det_zero;

  logic [COEF_W-1:0] limit, qsat, coef;
  logic              over;

  assign instr    = prog_rom(pc);
  assign few      = count < CNT_W'(min_points);
  assign rsh      = {r[DW-2:0], n[DW-1]};
  assign det_zero = (instr.dst == DST_D) && (add_res == '0);

  // The even power sums are never negative and may fill their whole field,
  // so they are zero-extended.
  always_comb begin
    case (instr.a)
      SRC_S4:  opa = DW'($unsigned(s_r.x4));
      SRC_S3:  opa = DW'(s_r.x3);
      SRC_S2:  opa = DW'($unsigned(s_r.x2));
      SRC_S1:  opa = DW'(s_r.x1);
      SRC_S0:  opa = DW'(used);
      SRC_T2:  opa = DW'(s_r.x2y);
      SRC_T1:  opa = DW'(s_r.xy);
      SRC_T0:  opa = DW'(s_r.y1);
      SRC_M0:  opa = m0;
      SRC_M1:  opa = m1;
      SRC_M2:  opa = m2;
      SRC_N1:  opa = n1;
      SRC_N2:  opa = n2;
      SRC_P2:  opa = p2;
      default: opa = '0;
    endcase
  end

  always_comb begin
    case (instr.b)
      SRC_S4:  opb = DW'($unsigned(s_r.x4));
      SRC_S3:  opb = DW'(s_r.x3);
      SRC_S2:  opb = DW'($unsigned(s_r.x2));
      SRC_S1:  opb = DW'(s_r.x1);
      SRC_S0:  opb = DW'(used);
      SRC_T2:  opb = DW'(s_r.x2y);
      SRC_T1:  opb = DW'(s_r.xy);
      SRC_T0:  opb = DW'(s_r.y1);
      SRC_M0:  opb = m0;
      SRC_M1:  opb = m1;
      SRC_M2:  opb = m2;
      SRC_N1:  opb = n1;
      SRC_N2:  opb = n2;
      SRC_P2:  opb = p2;
      default: opb = '0;
    endcase
  end

  always_comb begin
    case (k)
      2'd0:    num_sel = da;
      2'd1:    num_sel = db;
      default: num_sel = dc;
    endcase
  end

  // The one shared adder / subtractor.
  assign add_full = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + (DW+1)'(add_sub);
  assign add_res  = add_full[DW-1:0];
  assign carry    = add_full[DW];

  // Quotient saturation and sign.
  assign limit = neg ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
  assign over  = (|n[DW-1:COEF_W]) || (n[COEF_W-1:0] > limit);
  assign qsat  = over ? limit : n[COEF_W-1:0];
  assign coef  = neg ? (~qsat + COEF_W'(1)) : qsat;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      SV_IDLE: if (start) state_next = few ? SV_DONE : SV_LOAD;
      SV_LOAD: state_next = SV_MUL;
      SV_MUL:  if (cnt == MC_W'(DW - 1)) state_next = SV_MAC;
      SV_MAC: begin
        if (det_zero) state_next = SV_DONE;
        else if (pc == PC_W'(PROG_LEN - 1)) state_next = SV_ABSD;
        else state_next = SV_LOAD;
      end
      SV_ABSD: state_next = SV_ABSN;
      SV_ABSN: state_next = SV_DIV;
      SV_DIV:  if (cnt == MC_W'(DW - 1)) state_next = SV_QUOT;
      SV_QUOT: state_next = (k == 2'd2) ? SV_DONE : SV_ABSN;
      SV_DONE: if (ack) state_next = SV_IDLE;
      default: state_next = SV_IDLE;
    endcase
  end

  // Adder operands by state.
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    done    = 1'b0;
    unique case (state)
      SV_MUL: begin
        add_a = prod;
        add_b = ma;
      end
      SV_MAC: begin
        add_a   = (instr.mode == MAC_LOAD) ? '0 : acc;
        add_b   = prod;
        add_sub = (instr.mode == MAC_SUB);
      end
      SV_ABSD: begin
        add_b   = d_r;
        add_sub = d_r[DW-1];
      end
      SV_ABSN: begin
        add_b   = num_sel;
        add_sub = num_sel[DW-1];
      end
      SV_DIV: begin
        add_a   = rsh;
        add_b   = den;
        add_sub = 1'b1;
      end
      SV_DONE: done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SV_IDLE;
      pc    <= '0;
      cnt   <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      case (state)
        SV_IDLE: pc <= '0;
        SV_LOAD: cnt <= '0;
        SV_MUL:  cnt <= cnt + MC_W'(1);
        SV_MAC:  pc <= pc + PC_W'(1);
        SV_ABSD: k <= '0;
        SV_ABSN: cnt <= '0;
        SV_DIV:  cnt <= cnt + MC_W'(1);
        SV_QUOT: k <= k + 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      SV_IDLE: begin
        if (start) begin
          s_r        <= sums;
          used       <= count;
          ovf        <= overflow;
          sat        <= 1'b0;
          res.coef_a <= '0;
          res.coef_b <= '0;
          res.coef_c <= '0;
          res.count  <= count;
          res.status <= few ? ST_FEW : ST_OK;
        end
      end
      SV_LOAD: begin
        ma   <= opa;
        mb   <= opb;
        prod <= '0;
      end
      SV_MUL: begin
        if (mb[0]) prod <= add_res;
        ma <= {ma[DW-2:0], 1'b0};
        mb <= {1'b0, mb[DW-1:1]};
      end
      SV_MAC: begin
        acc <= add_res;
        case (instr.dst)
          DST_M0: m0 <= add_res;
          DST_M1: m1 <= add_res;
          DST_M2: m2 <= add_res;
          DST_N1: n1 <= add_res;
          DST_N2: n2 <= add_res;
          DST_P2: p2 <= add_res;
          DST_D:  d_r <= add_res;
          DST_DA: da <= add_res;
          DST_DB: db <= add_res;
          DST_DC: dc <= add_res;
          default: ;
        endcase
        if (det_zero) res.status <= ST_SINGULAR;
      end
      SV_ABSD: den <= add_res;
      SV_ABSN: begin
        n   <= add_res << FRAC_BITS;
        r   <= '0;
        neg <= num_sel[DW-1] ^ d_r[DW-1];
      end
      SV_DIV: begin
        r <= carry ? add_res : rsh;
        n <= {n[DW-2:0], carry};
      end
      SV_QUOT: begin
        sat <= sat | over;
        case (k)
          2'd0:    res.coef_a <= coef;
          2'd1:    res.coef_b <= coef;
          default: res.coef_c <= coef;
        endcase
        if (k == 2'd2) res.status <= (sat | over) ? ST_SAT : (ovf ? ST_DROPPED : ST_OK);
      end
      default: ;
    endcase
  end

  a_failed_fit_zero: assert property (@(posedge clk) disable iff (rst)
    (state == SV_DONE && (res.status == ST_FEW || res.status == ST_SINGULAR))
      |-> (res.coef_a == '0 && res.coef_b == '0 && res.coef_c == '0))
    else $error("failed fit reports nonzero coefficients");

  a_mac_after_full_mul: assert property (@(posedge clk) disable iff (rst)
    (state == SV_MAC) |-> ($past(state) == SV_MUL && $past(cnt) == MC_W'(DW - 1)))
    else $error("accumulate step without a complete multiply");

  a_singular_ends: assert property (@(posedge clk) disable iff (rst)
    (state == SV_MAC && det_zero) |=> (state == SV_DONE && res.status == ST_SINGULAR))
    else $error("zero determinant did not end the solve");

endmodule
`default_nettype wire

[rtl/quadratic_least_squares_fit_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// quadratic_least_squares_fit_top
// Least-squares fit of y = a*x^2 + b*x + c over a set of sample points.
// ============================================================================
//
//  Channel  Handshake             Payload
//  -------  --------------------  ---------------------------------------------
//  in       in_valid / in_ready   x_value, y_value, last
//  out      out_valid / out_ready coef_a, coef_b, coef_c, status, point_count
//  cfg      cfg_valid / cfg_ready cfg_data (min_points)
//
// For each point the abscissa is squared first, then all products are added
// into the power sums; only then is the next point taken. A point marked last
// starts the solve, which runs 24 shift-add multiplies and three restoring
// divides on one 128-bit adder; a too-few or singular set ends early.
// The result sits in an output register, so the next set can stream in while
// it waits to be taken; only a second solve waits for that register to free.
// Reset is synchronous and clears the sums, the count and min_points to 4.
//
// The sums and count are exact; the determinants are computed modulo 2^128.
// Each coefficient is the numerator shifted left by FRAC_BITS, divided by the
// determinant, truncated toward zero and saturated to 32 bits.
module quadratic_least_squares_fit_top
  import qlsf_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] x_value,
  input  wire logic signed [SAMPLE_BITS-1:0] y_value,
  input  wire logic                          last,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [COEF_W-1:0]           coef_a,
  output logic signed [COEF_W-1:0]           coef_b,
  output logic signed [COEF_W-1:0]           coef_c,
  output logic [2:0]                         status,
  output logic [CNT_W-1:0]                   point_count,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [CFG_W-1:0]              cfg_data
);

  top_state_t state, state_next;

  logic             take;
  logic             last_r;
  logic             acc_add;
  logic             acc_clear;
  logic             sv_start;
  logic             sv_done;
  logic             load;
  logic [CFG_W-1:0] min_points;

  sums_t            sums;
  logic [CNT_W-1:0] acc_count;
  logic             acc_overflow;
  result_t          sv_res;
  result_t          out_r;

  assign take      = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // The threshold is only looked at when a solve starts, so a write is
  // accepted in any cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_points <= MIN_POINTS_RST;
    end else if (cfg_valid && cfg_ready) begin
      min_points <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (take) last_r <= last;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      T_IDLE:  if (take) state_next = T_ACC;
      T_ACC:   state_next = last_r ? T_START : T_IDLE;
      T_START: state_next = T_SOLVE;
      T_SOLVE: if (load) state_next = T_IDLE;
      default: state_next = T_IDLE;
    endcase
  end

  // Control outputs. The solver latches the sums at its start, so the
  // accumulator is cleared in the same cycle.
  always_comb begin
    in_ready  = 1'b0;
    acc_add   = 1'b0;
    acc_clear = 1'b0;
    sv_start  = 1'b0;
    load      = 1'b0;
    unique case (state)
      T_IDLE:  in_ready = 1'b1;
      T_ACC:   acc_add = 1'b1;
      T_START: begin
        sv_start  = 1'b1;
        acc_clear = 1'b1;
      end
      T_SOLVE: load = sv_done && (!out_valid || out_ready);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
    end else begin
      state <= state_next;
    end
  end

  qlsf_accum u_accum (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .x_value  (x_value),
    .y_value  (y_value),
    .add_en   (acc_add),
    .clear    (acc_clear),
    .sums     (sums),
    .count    (acc_count),
    .overflow (acc_overflow)
  );

  qlsf_solver u_solver (
    .clk        (clk),
    .rst        (rst),
    .start      (sv_start),
    .sums       (sums),
    .count      (acc_count),
    .overflow   (acc_overflow),
    .min_points (min_points),
    .ack        (load),
    .done       (sv_done),
    .res        (sv_res)
  );

  // Output register: holds one result item until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_r <= sv_res;
  end

  assign coef_a      = out_r.coef_a;
  assign coef_b      = out_r.coef_b;
  assign coef_c      = out_r.coef_c;
  assign status      = out_r.status;
  assign point_count = out_r.count;

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    take |=> !in_ready)
    else $error("input taken again while a point is being added");

  a_solve_has_points: assert property (@(posedge clk) disable iff (rst)
    sv_start |-> (acc_count != '0))
    else $error("solve started on an empty set");

  a_load_when_done: assert property (@(posedge clk) disable iff (rst)
    load |-> (sv_done && (!out_valid || out_ready)))
    else $error("result loaded before the solve finished or over a waiting item");

endmodule
`default_nettype wire
